[rtl/nps_pkg.sv]
// package for the next prime search block: defaults, constants and sequencer states
`default_nettype none

package nps_pkg;

  // default width of the value path
  localparam int unsigned VALUE_BITS_DEF = 31;

  // trial division constants
  localparam int unsigned FIRST_WHEEL_DIV = 5;
  localparam int unsigned WHEEL_STEP      = 6;
  localparam int unsigned PAIR_OFFSET     = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_DIV3,
    S_LOOP,
    S_DIVA,
    S_DIVB,
    S_ADVANCE,
    S_DONE
  } nps_state_e;

endpackage

`default_nettype wire

[rtl/nps_if.sv]
// valid/ready channel interfaces for the next prime search block
`default_nettype none

interface nps_in_if #(
  parameter int unsigned WIDTH = 31
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] start_value;

  modport source (output valid, output start_value, input ready);
  modport sink   (input valid, input start_value, output ready);
endinterface

interface nps_out_if #(
  parameter int unsigned WIDTH = 31
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] prime_found;
  logic             overflow;

  modport source (output valid, output prime_found, output overflow, input ready);
  modport sink   (input valid, input prime_found, input overflow, output ready);
endinterface

`default_nettype wire

[rtl/nps_divider.sv]
// restoring remainder unit, one quotient bit per cycle
`default_nettype none

module nps_divider #(
  parameter int unsigned WIDTH = 31
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  input  wire logic [WIDTH-1:0] divisor_i,
  output logic                  done_o,
  output logic      [WIDTH-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] quo_q, dvs_q, rem_q;
  logic [WIDTH:0]   shifted, diff;

  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WIDTH);
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[WIDTH-2:0], 1'b0};
      if (!diff[WIDTH]) begin
        rem_q <= diff[WIDTH-1:0];
      end else begin
        rem_q <= shifted[WIDTH-1:0];
      end
    end
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dvs_q) || (dvs_q == '0))
    else $error("remainder not below divisor");

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

[rtl/next_prime_search.sv]
// top level of the next prime search block: sequencer around a shared remainder unit
//
//   channel  dir  payload                           transaction
//   in_i     in   start_value                       one search request
//   out_o    out  prime_found, overflow             one result per request
//
// - one request at a time; in_i.ready is high only while the block is idle
// - each remainder is worked out in the shared divider, which sets the rate
// - an even candidate passes through S_TEST and S_ADVANCE, while 2 or 3 goes from S_TEST to S_DONE;
//   an odd one is divided by 3, then by each 6k+-1 pair up to its square root, and passes through
//   S_ADVANCE when rejected; gaps between primes multiply this
// - the result sits in an output register until out_o.ready; no request is taken meanwhile
// - asynchronous active-low reset returns the sequencer to idle
`default_nettype none

module next_prime_search
  import nps_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nps_in_if.sink    in_i,
  nps_out_if.source out_o
);

  // square of the running divisor overshoots the candidate by a bounded amount
  localparam int unsigned SqBits = VALUE_BITS + 3;
  localparam logic [VALUE_BITS-1:0] TopValue = '1;

  nps_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] cand_q, cand_d;
  logic [VALUE_BITS-1:0] div_q, div_d;       // current wheel divisor 6k-1
  logic [SqBits-1:0]     sq_q, sq_d;         // div_q squared, kept incrementally
  logic [VALUE_BITS-1:0] res_prime_q, res_prime_d;
  logic                  res_ovf_q, res_ovf_d;
  logic [VALUE_BITS-1:0] start_q, start_d;

  logic                  dv_start;
  logic [VALUE_BITS-1:0] dv_divisor;
  logic                  dv_done;
  logic [VALUE_BITS-1:0] dv_rem;

  nps_divider #(
    .WIDTH (VALUE_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dv_start),
    .dividend_i  (cand_q),
    .divisor_i   (dv_divisor),
    .done_o      (dv_done),
    .remainder_o (dv_rem)
  );

  always_comb begin
    state_d     = state_q;
    cand_d      = cand_q;
    div_d       = div_q;
    sq_d        = sq_q;
    res_prime_d = res_prime_q;
    res_ovf_d   = res_ovf_q;
    start_d     = start_q;
    dv_start    = 1'b0;
    dv_divisor  = div_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          start_d = in_i.start_value;
          if (in_i.start_value == TopValue) begin
            // nothing wider fits, report overflow straight away
            res_prime_d = '0;
            res_ovf_d   = 1'b1;
            state_d     = S_DONE;
          end else begin
            cand_d  = in_i.start_value + VALUE_BITS'(1);
            state_d = S_TEST;
          end
        end
      end

      S_TEST: begin
        if (cand_q < VALUE_BITS'(2)) begin
          state_d = S_ADVANCE;
        end else if (cand_q < VALUE_BITS'(4)) begin
          // two and three are prime
          res_prime_d = cand_q;
          res_ovf_d   = 1'b0;
          state_d     = S_DONE;
        end else if (!cand_q[0]) begin
          state_d = S_ADVANCE;
        end else begin
          dv_start   = 1'b1;
          dv_divisor = VALUE_BITS'(3);
          state_d    = S_DIV3;
        end
      end

      S_DIV3: begin
        if (dv_done) begin
          if (dv_rem == '0) begin
            state_d = S_ADVANCE;
          end else begin
            div_d   = VALUE_BITS'(FIRST_WHEEL_DIV);
            sq_d    = SqBits'(FIRST_WHEEL_DIV * FIRST_WHEEL_DIV);
            state_d = S_LOOP;
          end
        end
      end

      S_LOOP: begin
        if (sq_q > SqBits'(cand_q)) begin
          // no divisor up to the square root, candidate is prime
          res_prime_d = cand_q;
          res_ovf_d   = 1'b0;
          state_d     = S_DONE;
        end else begin
          dv_start   = 1'b1;
          dv_divisor = div_q;
          state_d    = S_DIVA;
        end
      end

      S_DIVA: begin
        if (dv_done) begin
          if (dv_rem == '0) begin
            state_d = S_ADVANCE;
          end else begin
            dv_start   = 1'b1;
            dv_divisor = div_q + VALUE_BITS'(PAIR_OFFSET);
            state_d    = S_DIVB;
          end
        end
      end

      S_DIVB: begin
        if (dv_done) begin
          if (dv_rem == '0) begin
            state_d = S_ADVANCE;
          end else begin
            // (d + 6)^2 = d^2 + 12d + 36
            div_d   = div_q + VALUE_BITS'(WHEEL_STEP);
            sq_d    = sq_q + (SqBits'(div_q) << 3) + (SqBits'(div_q) << 2)
                      + SqBits'(WHEEL_STEP * WHEEL_STEP);
            state_d = S_LOOP;
          end
        end
      end

      S_ADVANCE: begin
        if (cand_q == TopValue) begin
          res_prime_d = '0;
          res_ovf_d   = 1'b1;
          state_d     = S_DONE;
        end else begin
          cand_d  = cand_q + VALUE_BITS'(1);
          state_d = S_TEST;
        end
      end

      S_DONE: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    cand_q      <= cand_d;
    div_q       <= div_d;
    sq_q        <= sq_d;
    res_prime_q <= res_prime_d;
    res_ovf_q   <= res_ovf_d;
    start_q     <= start_d;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_DONE);
  assign out_o.prime_found = res_prime_q;
  assign out_o.overflow    = res_ovf_q;

  // overflow result carries a zero value
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow) |-> (out_o.prime_found == '0))
    else $error("overflow result with non-zero value");

  // a found prime lies above the request
  a_above_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.overflow) |-> (out_o.prime_found > start_q))
    else $error("result not above start value");

  // the divider only finishes while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_done |-> (state_q == S_DIV3 || state_q == S_DIVA || state_q == S_DIVB))
    else $error("divider result outside a wait state");

  // a candidate under test is odd once trial division has begun
  a_odd_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOP) |-> cand_q[0])
    else $error("even candidate in trial division");

endmodule

`default_nettype wire
